[rtl/sps_pkg.sv]
// Shared types, codes and constants of the stepper phase sequencer.
package sps_pkg;

   // Default timing base: ticks of elapsed_us per second
   localparam int unsigned TICKS_PER_SECOND_DEF = 1000000;

   // Configuration port geometry
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_PAT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PAT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_NUM = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_DEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_MIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_MAX  = 3'd5;

   // Configuration reset values
   localparam logic [15:0] FULL_PAT_RST  = 16'h0000;
   localparam logic [31:0] HALF_PAT_RST  = 32'h0000_0000;
   localparam logic [7:0]  ANGLE_NUM_RST = 8'd15;
   localparam logic [7:0]  ANGLE_DEN_RST = 8'd2;
   localparam logic [15:0] RATE_MIN_RST  = 16'd1;
   localparam logic [15:0] RATE_MAX_RST  = 16'd65535;

   // Command codes
   localparam logic [2:0] FUNC_TICK      = 3'd0;
   localparam logic [2:0] FUNC_RUN_STEPS = 3'd1;
   localparam logic [2:0] FUNC_RUN_DEG   = 3'd2;
   localparam logic [2:0] FUNC_RUN_SEC   = 3'd3;
   localparam logic [2:0] FUNC_STOP      = 3'd4;

   // Direction and excitation codes
   localparam logic [7:0] DIR_CW    = 8'd0;
   localparam logic [7:0] DIR_CCW   = 8'd1;
   localparam logic [7:0] EXC_FULL  = 8'd0;
   localparam logic [7:0] EXC_HALF  = 8'd1;

   // Input item
   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] elapsed_us;
      logic [15:0] step_rate;
      logic [15:0] amount;
      logic [7:0]  direction;
      logic [7:0]  excitation;
   } req_type;

   // Result item
   typedef struct packed {
      logic [3:0]  coil_pins;
      logic        accepted;
      logic        running;
      logic [31:0] steps_done;
   } rsp_type;

   // Shared arithmetic unit
   localparam int unsigned UNIT_A_W = 32;
   localparam int unsigned UNIT_B_W = 16;
   localparam int unsigned UNIT_P_W = UNIT_A_W + UNIT_B_W;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } unit_op_type;

   typedef struct packed {
      logic                start;
      unit_op_type         op;
      logic [UNIT_A_W-1:0] opa;
      logic [UNIT_B_W-1:0] opb;
   } unit_req_type;

   typedef struct packed {
      logic                done;
      logic [UNIT_P_W-1:0] result;
   } unit_rsp_type;

endpackage

[rtl/stepper_phase_sequencer.sv]
// Top level of the stepper coil phase sequencer.
//
// Usage: items arrive on req_* (valid/ready). func selects a tick (adds elapsed_us
// to the time accumulator and may drive one step), a run by steps, degrees or
// seconds, or a stop. Every item gives exactly one result on rsp_* (valid/ready):
// the coil levels, whether the command was accepted, the running flag and the
// step count of the current run, all as they stand after the item.
// Registers are written on csr_* (enable, index, data); the user must do so only
// while the block is idle, which the block itself does not enforce. One item at
// a time; req_ready is high only in the idle state. Stops, unknown codes,
// rejected runs, runs by steps, runs by degrees with a zero angle numerator and
// ticks while stopped go straight to the done state. A tick while running and a
// run by seconds each use one 16-bit shift-add multiply. A run by degrees uses a
// 16-bit multiply then a 32-step restoring divide, both on the one shared unit.
// A finished result waits in the output register; the next item may already
// be accepted, but its result is held back until that register is taken.
// Reset (synchronous) stops the motor, drives all coils low and loads the
// register defaults.
module stepper_phase_sequencer #(
   parameter int unsigned TICKS_PER_SECOND = sps_pkg::TICKS_PER_SECOND_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sps_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sps_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [sps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [sps_pkg::UNIT_P_W-1:0] TPS_LIMIT =
      sps_pkg::UNIT_P_W'(TICKS_PER_SECOND);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TICK_GO,
      ST_TICK_WAIT,
      ST_SEC_GO,
      ST_SEC_WAIT,
      ST_DEG_MUL_GO,
      ST_DEG_MUL_WAIT,
      ST_DEG_DIV_GO,
      ST_DEG_DIV_WAIT,
      ST_DONE
   } state_type;

   // Configuration registers
   logic [15:0] full_pat_ff;
   logic [31:0] half_pat_ff;
   logic [7:0]  angle_num_ff;
   logic [7:0]  angle_den_ff;
   logic [15:0] rate_min_ff;
   logic [15:0] rate_max_ff;

   // Sequencer and motor state
   state_type        state_ff, state_in;
   logic             running_ff, running_in;
   logic [2:0]       phase_ff, phase_in;
   logic             half_ff, half_in;
   logic             ccw_ff, ccw_in;
   logic [31:0]      target_ff, target_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      tacc_ff, tacc_in;
   logic [3:0]       pins_ff, pins_in;
   logic [15:0]      freq_ff, freq_in;
   logic [15:0]      amount_ff, amount_in;
   logic             ok_ff, ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   sps_pkg::unit_req_type unit_req;
   sps_pkg::unit_rsp_type unit_rsp;

   logic [32:0] tacc_sum;
   logic        run_ok;
   logic        req_half;
   logic        req_ccw;
   logic [2:0]  phase_base;
   logic [2:0]  phase_pre;

   // Phase moves, wrapping at 4 or 8
   function automatic logic [2:0] phase_up(input logic [2:0] p, input logic half);
      logic [3:0] nxt;
      logic [3:0] lim;
      nxt = {1'b0, p} + 4'd1;
      lim = half ? 4'd8 : 4'd4;
      return (nxt >= lim) ? 3'd0 : nxt[2:0];
   endfunction

   function automatic logic [2:0] phase_down(input logic [2:0] p, input logic half);
      logic [2:0] top;
      top = half ? 3'd7 : 3'd3;
      return (p == 3'd0) ? top : p - 3'd1;
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         full_pat_ff  <= sps_pkg::FULL_PAT_RST;
         half_pat_ff  <= sps_pkg::HALF_PAT_RST;
         angle_num_ff <= sps_pkg::ANGLE_NUM_RST;
         angle_den_ff <= sps_pkg::ANGLE_DEN_RST;
         rate_min_ff  <= sps_pkg::RATE_MIN_RST;
         rate_max_ff  <= sps_pkg::RATE_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sps_pkg::CSR_FULL_PAT:  full_pat_ff  <= csr_wdata[15:0];
            sps_pkg::CSR_HALF_PAT:  half_pat_ff  <= csr_wdata[31:0];
            sps_pkg::CSR_ANGLE_NUM: angle_num_ff <= csr_wdata[7:0];
            sps_pkg::CSR_ANGLE_DEN: angle_den_ff <= csr_wdata[7:0];
            sps_pkg::CSR_RATE_MIN:  rate_min_ff  <= csr_wdata[15:0];
            sps_pkg::CSR_RATE_MAX:  rate_max_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Command decode helpers
   always_comb begin
      tacc_sum   = {1'b0, tacc_ff} + {17'd0, req_data.elapsed_us};
      req_half   = (req_data.excitation == sps_pkg::EXC_HALF);
      req_ccw    = (req_data.direction == sps_pkg::DIR_CCW);
      run_ok     = (req_data.step_rate >= rate_min_ff) &&
                   (req_data.step_rate <= rate_max_ff) &&
                   ((req_data.direction == sps_pkg::DIR_CW) || req_ccw) &&
                   ((req_data.excitation == sps_pkg::EXC_FULL) || req_half);
      // mode change restarts the phase, direction change pre-moves two places
      phase_base = (req_half != half_ff) ? 3'd0 : phase_ff;
      phase_pre  = phase_base;
      if (req_ccw != ccw_ff) begin
         if (req_ccw) begin
            phase_pre = phase_down(phase_down(phase_base, req_half), req_half);
         end else begin
            phase_pre = phase_up(phase_up(phase_base, req_half), req_half);
         end
      end
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      phase_in     = phase_ff;
      half_in      = half_ff;
      ccw_in       = ccw_ff;
      target_in    = target_ff;
      count_in     = count_ff;
      tacc_in      = tacc_ff;
      pins_in      = pins_ff;
      freq_in      = freq_ff;
      amount_in    = amount_ff;
      ok_in        = ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unit_req     = '{start: 1'b0, op: sps_pkg::OP_MUL, opa: '0, opb: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               amount_in = req_data.amount;
               ok_in     = 1'b0;
               state_in  = ST_DONE;
               unique case (req_data.func) inside
                  sps_pkg::FUNC_TICK: begin
                     ok_in   = 1'b1;
                     tacc_in = tacc_sum[32] ? '1 : tacc_sum[31:0];
                     if (running_ff) begin
                        state_in = ST_TICK_GO;
                     end
                  end
                  sps_pkg::FUNC_STOP: begin
                     ok_in      = 1'b1;
                     running_in = 1'b0;
                     tacc_in    = '0;
                     phase_in   = '0;
                     count_in   = '0;
                     pins_in    = '0;
                  end
                  sps_pkg::FUNC_RUN_STEPS, sps_pkg::FUNC_RUN_DEG,
                  sps_pkg::FUNC_RUN_SEC: begin
                     if (run_ok) begin
                        ok_in      = 1'b1;
                        freq_in    = req_data.step_rate;
                        ccw_in     = req_ccw;
                        half_in    = req_half;
                        count_in   = '0;
                        running_in = 1'b1;
                        if (req_data.func == sps_pkg::FUNC_RUN_SEC) begin
                           tacc_in  = '0;
                           phase_in = '0;
                           pins_in  = '0;
                           state_in = ST_SEC_GO;
                        end else begin
                           phase_in = phase_pre;
                           if (req_data.func == sps_pkg::FUNC_RUN_STEPS) begin
                              target_in = {16'd0, req_data.amount};
                           end else if (angle_num_ff == '0) begin
                              target_in = (req_data.amount == '0) ? '0 : '1;
                           end else begin
                              state_in = ST_DEG_MUL_GO;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end

         // accumulated time times rate against one second
         ST_TICK_GO: begin
            unit_req = '{start: 1'b1, op: sps_pkg::OP_MUL, opa: tacc_ff, opb: freq_ff};
            state_in = ST_TICK_WAIT;
         end
         ST_TICK_WAIT: begin
            if (unit_rsp.done) begin
               state_in = ST_DONE;
               if (unit_rsp.result >= TPS_LIMIT) begin
                  if ((target_ff != '0) && (count_ff >= target_ff)) begin
                     running_in = 1'b0;
                     tacc_in    = '0;
                     phase_in   = '0;
                     count_in   = '0;
                     pins_in    = '0;
                  end else begin
                     pins_in  = half_ff ? half_pat_ff[{phase_ff, 2'b00} +: 4]
                                        : full_pat_ff[{phase_ff[1:0], 2'b00} +: 4];
                     phase_in = ccw_ff ? phase_down(phase_ff, half_ff)
                                       : phase_up(phase_ff, half_ff);
                     count_in = count_ff + 32'd1;
                     tacc_in  = '0;
                  end
               end
            end
         end

         // run by seconds: target is amount times rate
         ST_SEC_GO: begin
            unit_req = '{start: 1'b1, op: sps_pkg::OP_MUL,
                         opa: {16'd0, amount_ff}, opb: freq_ff};
            state_in = ST_SEC_WAIT;
         end
         ST_SEC_WAIT: begin
            if (unit_rsp.done) begin
               target_in = unit_rsp.result[31:0];
               state_in  = ST_DONE;
            end
         end

         // run by degrees: amount * den * m / num
         ST_DEG_MUL_GO: begin
            unit_req = '{start: 1'b1, op: sps_pkg::OP_MUL,
                         opa: {16'd0, amount_ff}, opb: {8'd0, angle_den_ff}};
            state_in = ST_DEG_MUL_WAIT;
         end
         ST_DEG_MUL_WAIT: begin
            if (unit_rsp.done) begin
               state_in = ST_DEG_DIV_GO;
            end
         end
         ST_DEG_DIV_GO: begin
            unit_req = '{start: 1'b1, op: sps_pkg::OP_DIV,
                         opa: half_ff ? {unit_rsp.result[30:0], 1'b0}
                                      : unit_rsp.result[31:0],
                         opb: {8'd0, angle_num_ff}};
            state_in = ST_DEG_DIV_WAIT;
         end
         ST_DEG_DIV_WAIT: begin
            if (unit_rsp.done) begin
               target_in = unit_rsp.result[31:0];
               state_in  = ST_DONE;
            end
         end

         // load the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = '{coil_pins: pins_ff, accepted: ok_ff,
                                running: running_ff, steps_done: count_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         phase_ff     <= '0;
         half_ff      <= 1'b0;
         ccw_ff       <= 1'b0;
         target_ff    <= '0;
         count_ff     <= '0;
         tacc_ff      <= '0;
         pins_ff      <= '0;
         freq_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         phase_ff     <= phase_in;
         half_ff      <= half_in;
         ccw_ff       <= ccw_in;
         target_ff    <= target_in;
         count_ff     <= count_in;
         tacc_ff      <= tacc_in;
         pins_ff      <= pins_in;
         freq_ff      <= freq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      amount_ff   <= amount_in;
      ok_ff       <= ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   sps_shift_unit u_shift_unit (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks

   // the shared unit only finishes while the sequencer waits on it
   a_unit_done_waited: assert property (@(posedge clock) disable iff (reset)
      unit_rsp.done |-> (state_ff == ST_TICK_WAIT || state_ff == ST_SEC_WAIT ||
                         state_ff == ST_DEG_MUL_WAIT || state_ff == ST_DEG_DIV_WAIT))
      else $error("shift unit done outside a wait state");

   // coils are released whenever the motor is stopped
   a_idle_coils_low: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (pins_ff == 4'd0))
      else $error("coils driven while stopped");

   // full-step phase stays within four places
   a_full_phase_range: assert property (@(posedge clock) disable iff (reset)
      !half_ff |-> (phase_ff[2] == 1'b0))
      else $error("full-step phase out of range");

   // a bounded run never counts past its target
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (target_ff != 32'd0) |-> (count_ff <= target_ff))
      else $error("step count beyond target");

endmodule

[rtl/sps_shift_unit.sv]
// Shared bit-serial multiplier and restoring divider of the phase sequencer.
module sps_shift_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  sps_pkg::unit_req_type unit_req,
   output sps_pkg::unit_rsp_type unit_rsp
);

   localparam int unsigned A_W      = sps_pkg::UNIT_A_W;
   localparam int unsigned B_W      = sps_pkg::UNIT_B_W;
   localparam int unsigned P_W      = sps_pkg::UNIT_P_W;
   localparam int unsigned DIVS_W   = 8;
   localparam int unsigned CNT_W    = $clog2(A_W);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(B_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(A_W - 1);

   sps_pkg::unit_op_type op_ff, op_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [P_W-1:0]    prod_ff, prod_in;
   logic [P_W-1:0]    mcand_ff, mcand_in;
   logic [B_W-1:0]    mplier_ff, mplier_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;

   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;
   logic              ge;

   // One multiply bit or one quotient bit per cycle
   always_comb begin
      op_in     = op_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      prod_in   = prod_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;

      // divisor sits in the low bits of the multiplier register
      trial = {rem_ff, prod_ff[A_W-1]};
      ge    = (trial >= {1'b0, mplier_ff[DIVS_W-1:0]});
      diff  = trial - {1'b0, mplier_ff[DIVS_W-1:0]};

      if (unit_req.start) begin
         op_in     = unit_req.op;
         busy_in   = 1'b1;
         mplier_in = unit_req.opb;
         rem_in    = '0;
         if (unit_req.op == sps_pkg::OP_MUL) begin
            cnt_in   = MUL_LAST;
            prod_in  = '0;
            mcand_in = {{B_W{1'b0}}, unit_req.opa};
         end else begin
            cnt_in  = DIV_LAST;
            prod_in = {{B_W{1'b0}}, unit_req.opa};
         end
      end else if (busy_ff) begin
         if (op_ff == sps_pkg::OP_MUL) begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[P_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[B_W-1:1]};
         end else begin
            rem_in  = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            prod_in = {{B_W{1'b0}}, prod_ff[A_W-2:0], ge};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      prod_ff   <= prod_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
   end

   assign unit_rsp = '{done: done_ff, result: prod_ff};

endmodule

[bench/stepper_phase_sequencer_test.sv]
// Self-checking testbench for the stepper phase sequencer: command driver, status monitor, model.
`timescale 1ns / 1ps

module stepper_phase_sequencer_test;

   // Idling is switched off on both sides inside this window of transfers
   localparam int QUIET_FROM = 30;
   localparam int QUIET_TO   = 200;

   logic clock;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   sps_pkg::req_type                      req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   sps_pkg::rsp_type                      rsp_data;
   logic                                  csr_we    = 1'b0;
   logic [sps_pkg::CSR_IDX_W-1:0]         csr_index = '0;
   logic [sps_pkg::CSR_DATA_W-1:0]        csr_wdata = '0;

   stepper_phase_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Commands waiting to be offered, and coil status still owed by the block
   sps_pkg::req_type cmd_queue[$];
   sps_pkg::rsp_type expected_status[$];

   int commands_sent   = 0;
   int statuses_seen   = 0;
   int mismatch_count  = 0;
   int runs_started    = 0;
   int runs_rejected   = 0;
   int coil_steps      = 0;
   int target_stops    = 0;
   int accum_clips     = 0;

   // Back-pressure spell bookkeeping
   int hold_left;
   bit held_once;

   // Register copies
   logic [15:0] cfg_full;
   logic [31:0] cfg_half;
   logic [7:0]  cfg_num;
   logic [7:0]  cfg_den;
   logic [15:0] cfg_rmin;
   logic [15:0] cfg_rmax;

   // Motor state copies
   logic        mot_running = 1'b0;
   logic [2:0]  mot_phase   = '0;
   logic        mot_half    = 1'b0;
   logic        mot_ccw     = 1'b0;
   logic [31:0] mot_target  = '0;
   logic [31:0] mot_count   = '0;
   logic [31:0] mot_accum   = '0;
   logic [3:0]  mot_pins    = '0;
   logic [15:0] mot_rate    = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic sps_pkg::req_type motion_cmd(logic [2:0] f, int us, int rate,
                                                   int amt, int dir, int exc);
      sps_pkg::req_type c;
      c.func       = f;
      c.elapsed_us = us[15:0];
      c.step_rate  = rate[15:0];
      c.amount     = amt[15:0];
      c.direction  = dir[7:0];
      c.excitation = exc[7:0];
      return c;
   endfunction

   // One phase place forwards or backwards, wrapping at 4 or 8
   function automatic logic [2:0] phase_move(logic [2:0] p, logic half, logic down);
      logic [2:0] last;
      last = half ? 3'd7 : 3'd3;
      if (down)
         return (p == 3'd0) ? last : p - 3'd1;
      return (p >= last) ? 3'd0 : p + 3'd1;
   endfunction

   task automatic halt_motor_model();
      mot_running = 1'b0;
      mot_accum   = '0;
      mot_phase   = '0;
      mot_count   = '0;
      mot_pins    = '0;
   endtask

   // Motor behaviour for one command; gives the status the block must report
   task automatic advance_motor(input sps_pkg::req_type it, output sps_pkg::rsp_type st);
      logic [32:0] sum;
      logic [63:0] prod;
      logic        ok;
      logic        half;
      logic        ccw;
      ok   = 1'b0;
      half = (it.excitation == sps_pkg::EXC_HALF);
      ccw  = (it.direction == sps_pkg::DIR_CCW);
      case (it.func) inside
         sps_pkg::FUNC_TICK: begin
            ok  = 1'b1;
            sum = {1'b0, mot_accum} + 33'(it.elapsed_us);
            if (sum[32]) accum_clips++;
            mot_accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (mot_running &&
                64'(mot_accum) * 64'(mot_rate) >= 64'(sps_pkg::TICKS_PER_SECOND_DEF)) begin
               if (mot_target != 0 && mot_count >= mot_target) begin
                  halt_motor_model();
                  target_stops++;
               end else begin
                  mot_pins = mot_half ? cfg_half[{mot_phase, 2'b00} +: 4]
                                      : cfg_full[{mot_phase[1:0], 2'b00} +: 4];
                  mot_phase = phase_move(mot_phase, mot_half, mot_ccw);
                  mot_count = mot_count + 32'd1;
                  mot_accum = '0;
                  coil_steps++;
               end
            end
         end
         sps_pkg::FUNC_STOP: begin
            ok = 1'b1;
            halt_motor_model();
         end
         sps_pkg::FUNC_RUN_STEPS, sps_pkg::FUNC_RUN_DEG, sps_pkg::FUNC_RUN_SEC: begin
            if (it.step_rate >= cfg_rmin && it.step_rate <= cfg_rmax &&
                it.direction <= sps_pkg::DIR_CCW && it.excitation <= sps_pkg::EXC_HALF) begin
               ok = 1'b1;
               if (it.func == sps_pkg::FUNC_RUN_SEC) begin
                  halt_motor_model();
                  mot_target = 32'(it.amount) * 32'(it.step_rate);
               end else begin
                  if (half != mot_half) mot_phase = '0;
                  // direction reversal pre-moves two places in the new mode
                  if (ccw != mot_ccw)
                     mot_phase = phase_move(phase_move(mot_phase, half, ccw), half, ccw);
                  if (it.func == sps_pkg::FUNC_RUN_STEPS) begin
                     mot_target = 32'(it.amount);
                  end else if (cfg_num == 8'd0) begin
                     // no step angle: zero stays endless, anything else never ends
                     mot_target = (it.amount == 16'd0) ? 32'd0 : 32'hFFFF_FFFF;
                  end else begin
                     prod = 64'(it.amount) * 64'(cfg_den) * (half ? 64'd2 : 64'd1);
                     mot_target = 32'(prod / 64'(cfg_num));
                  end
               end
               mot_rate    = it.step_rate;
               mot_ccw     = ccw;
               mot_half    = half;
               mot_count   = '0;
               mot_running = 1'b1;
               runs_started++;
            end else begin
               runs_rejected++;
            end
         end
         default: ;
      endcase
      st.coil_pins  = mot_pins;
      st.accepted   = ok;
      st.running    = mot_running;
      st.steps_done = mot_count;
   endtask

   // Command driver: offers queued commands, idles at random
   always @(posedge clock) begin : drive_commands
      sps_pkg::rsp_type predicted;
      bit               idles;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            advance_motor(req_data, predicted);
            expected_status.push_back(predicted);
            commands_sent++;
         end
         if (!req_valid || req_ready) begin
            idles = (commands_sent < QUIET_FROM || commands_sent > QUIET_TO) &&
                    ($urandom_range(0, 99) < 36);
            if (cmd_queue.size() != 0 && !idles) begin
               req_valid <= 1'b1;
               req_data  <= cmd_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // One long back-pressure spell so the block fills and stalls its input
   always @(posedge clock) begin : hold_receiver
      if (reset) begin
         hold_left <= 0;
         held_once <= 1'b0;
      end else if (!held_once && statuses_seen >= 150) begin
         held_once <= 1'b1;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Status monitor: checks each transfer against the oldest prediction
   always @(posedge clock) begin : check_status
      sps_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            statuses_seen++;
            if (expected_status.size() == 0) begin
               mismatch_count++;
               $display("%0t: status %h with no command outstanding", $time, rsp_data);
            end else begin
               want = expected_status.pop_front();
               if (rsp_data.coil_pins !== want.coil_pins) begin
                  mismatch_count++;
                  $display("%0t: coil_pins expected %h actual %h",
                           $time, want.coil_pins, rsp_data.coil_pins);
               end
               if (rsp_data.accepted !== want.accepted) begin
                  mismatch_count++;
                  $display("%0t: accepted expected %b actual %b",
                           $time, want.accepted, rsp_data.accepted);
               end
               if (rsp_data.running !== want.running) begin
                  mismatch_count++;
                  $display("%0t: running expected %b actual %b",
                           $time, want.running, rsp_data.running);
               end
               if (rsp_data.steps_done !== want.steps_done) begin
                  mismatch_count++;
                  $display("%0t: steps_done expected %0d actual %0d",
                           $time, want.steps_done, rsp_data.steps_done);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !((statuses_seen < QUIET_FROM || statuses_seen > QUIET_TO) &&
                           ($urandom_range(0, 99) < 36));
         end
      end
   end

   task automatic program_regs(logic [15:0] full, logic [31:0] half, logic [7:0] num,
                               logic [7:0] den, logic [15:0] rmin, logic [15:0] rmax);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= sps_pkg::CSR_FULL_PAT;  csr_wdata <= 32'(full);
      @(posedge clock);
      csr_index <= sps_pkg::CSR_HALF_PAT;  csr_wdata <= half;
      @(posedge clock);
      csr_index <= sps_pkg::CSR_ANGLE_NUM; csr_wdata <= 32'(num);
      @(posedge clock);
      csr_index <= sps_pkg::CSR_ANGLE_DEN; csr_wdata <= 32'(den);
      @(posedge clock);
      csr_index <= sps_pkg::CSR_RATE_MIN;  csr_wdata <= 32'(rmin);
      @(posedge clock);
      csr_index <= sps_pkg::CSR_RATE_MAX;  csr_wdata <= 32'(rmax);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_full = full; cfg_half = half; cfg_num = num;
      cfg_den  = den;  cfg_rmin = rmin; cfg_rmax = rmax;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (cmd_queue.size() != 0 || req_valid || expected_status.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Runs with random content followed by tick bursts, plus some noise commands
   task automatic queue_motion_bursts(int n_items);
      int         left;
      int         pick;
      int         rate;
      int         amt;
      int         dir;
      int         exc;
      int         hi;
      int         thr;
      int         us;
      int         n_ticks;
      logic [2:0] fn;
      left = n_items;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            case ($urandom_range(0, 4))
               0: fn = sps_pkg::FUNC_TICK;
               1: fn = sps_pkg::FUNC_RUN_STEPS;
               2: fn = sps_pkg::FUNC_RUN_DEG;
               3: fn = sps_pkg::FUNC_RUN_SEC;
               default: fn = sps_pkg::FUNC_STOP;
            endcase
            cmd_queue.push_back(motion_cmd(fn, $urandom_range(0, 65535),
               $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 255), $urandom_range(0, 255)));
            left--;
         end else begin
            case ($urandom_range(1, 3))
               1: fn = sps_pkg::FUNC_RUN_STEPS;
               2: fn = sps_pkg::FUNC_RUN_DEG;
               default: fn = sps_pkg::FUNC_RUN_SEC;
            endcase
            hi = (int'(cfg_rmin) + 3000 < int'(cfg_rmax)) ? int'(cfg_rmin) + 3000
                                                          : int'(cfg_rmax);
            if (cfg_rmin > cfg_rmax)
               rate = $urandom_range(0, 65535);
            else if ($urandom_range(0, 1))
               rate = $urandom_range(cfg_rmin, cfg_rmax);
            else
               rate = $urandom_range(cfg_rmin, hi);
            dir = $urandom_range(0, 1);
            exc = $urandom_range(0, 1);
            // malformed runs: bad direction, bad mode or any rate at all
            if (pick < 18) begin
               case ($urandom_range(0, 2))
                  0: dir = $urandom_range(2, 255);
                  1: exc = $urandom_range(2, 255);
                  default: rate = $urandom_range(0, 65535);
               endcase
            end
            pick = $urandom_range(0, 99);
            if (fn == sps_pkg::FUNC_RUN_STEPS)
               amt = (pick < 70) ? $urandom_range(1, 12)
                                 : (pick < 85) ? 0 : $urandom_range(0, 65535);
            else if (fn == sps_pkg::FUNC_RUN_DEG)
               amt = (pick < 70) ? $urandom_range(0, 30) : $urandom_range(0, 65535);
            else
               amt = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                   : $urandom_range(0, 65535);
            cmd_queue.push_back(motion_cmd(fn, $urandom_range(0, 65535), rate, amt,
                                           dir, exc));
            left--;
            n_ticks = $urandom_range(1, 16);
            for (int k = 0; k < n_ticks; k++) begin
               thr  = (rate == 0) ? 0 : (1000000 + rate - 1) / rate;
               pick = $urandom_range(0, 99);
               if (rate == 0 || thr > 65535)
                  us = (pick < 80) ? 65535 : $urandom_range(0, 65535);
               else if (pick < 60)
                  us = $urandom_range(thr, (thr * 2 > 65535) ? 65535 : thr * 2);
               else if (pick < 80)
                  us = $urandom_range(0, thr - 1);
               else
                  us = $urandom_range(0, 65535);
               cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, us, 0, 0, 0, 0));
               left--;
            end
            if ($urandom_range(0, 99) < 25) begin
               cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_STOP, 0, 0, 0, 0, 0));
               left--;
            end
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0]  num;
      logic [15:0] rmin;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each command, rejections, reversal and mode change
      program_regs(16'h9C63, 32'h98C4_6231, 8'd15, 8'd2, 16'd1, 16'd65535);
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 65535, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_STOP, 0, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_STEPS, 0, 0, 3, sps_pkg::DIR_CW,
                                     sps_pkg::EXC_FULL));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_STEPS, 0, 65535, 3, sps_pkg::DIR_CW,
                                     sps_pkg::EXC_FULL));
      repeat (4) cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 20, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_STEPS, 0, 50000, 0, sps_pkg::DIR_CCW,
                                     sps_pkg::EXC_HALF));
      repeat (2) cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 65535, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_DEG, 0, 1000, 65535, sps_pkg::DIR_CW,
                                     sps_pkg::EXC_FULL));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 1000, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_DEG, 0, 65535, 0, sps_pkg::DIR_CCW,
                                     sps_pkg::EXC_HALF));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 65535, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_SEC, 0, 65535, 65535, sps_pkg::DIR_CW,
                                     sps_pkg::EXC_FULL));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 65535, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_SEC, 0, 2, 1, sps_pkg::DIR_CCW,
                                     sps_pkg::EXC_HALF));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 65535, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_STEPS, 0, 100, 5, 2,
                                     sps_pkg::EXC_FULL));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_DEG, 0, 100, 5, sps_pkg::DIR_CW,
                                     255));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_SEC, 0, 65535, 5, 255, 255));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_STEPS, 65535, 65535, 65535,
                                     sps_pkg::DIR_CCW, sps_pkg::EXC_HALF));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_STOP, 65535, 65535, 65535, 255, 255));
      wait_idle();

      // Idle ticks build up the accumulator; a rate of one must then fire at once
      for (int i = 0; i < 20; i++)
         cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 65535, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 1, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_RUN_STEPS, 0, 1, 0, sps_pkg::DIR_CW,
                                     sps_pkg::EXC_FULL));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_TICK, 0, 0, 0, 0, 0));
      cmd_queue.push_back(motion_cmd(sps_pkg::FUNC_STOP, 0, 0, 0, 0, 0));
      wait_idle();

      // Large degree targets, full rate range
      program_regs(16'($urandom_range(0, 65535)), $urandom(), 8'd1, 8'd255, 16'd1,
                   16'd65535);
      queue_motion_bursts(200);
      wait_idle();

      // Tiny degree targets, only the top rate accepted
      program_regs(16'hFFFF, 32'h0000_0000, 8'd255, 8'd1, 16'd65535, 16'd65535);
      queue_motion_bursts(150);
      wait_idle();

      // Only the slowest rate accepted
      program_regs(16'($urandom_range(0, 65535)), 32'hFFFF_FFFF,
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 16'd1, 16'd1);
      queue_motion_bursts(80);
      wait_idle();

      // Random angle and window
      num  = 8'($urandom_range(1, 255));
      rmin = 16'($urandom_range(1, 30000));
      program_regs(16'($urandom_range(0, 65535)), $urandom(), num,
                   8'($urandom_range(1, 255)), rmin, 16'($urandom_range(rmin, 65535)));
      queue_motion_bursts(200);
      wait_idle();

      repeat (80) @(negedge clock);
      $display("covered %0d commands and %0d status transfers over 5 register settings",
               commands_sent, statuses_seen);
      $display("runs started %0d, rejected %0d, coil steps %0d, target stops %0d, clips %0d",
               runs_started, runs_rejected, coil_steps, target_stops, accum_clips);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/sps_pkg.sv
rtl/sps_shift_unit.sv
rtl/stepper_phase_sequencer.sv
bench/stepper_phase_sequencer_test.sv
